// ===== rtl/sip_pkg.sv =====
// shared types and constants for the stroke interpolator step pulser
// no dependencies; imported by sip_div and the top module
package sip_pkg;

   localparam int SEG_MAX    = 16;
   localparam int TICK_US    = 64;
   localparam int MAX_PULSES = 64;
   localparam int NUM_AXES   = 4;

   localparam int IDX_W  = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
   localparam int LEN_W  = $clog2(SEG_MAX + 1);
   localparam int CNT_W  = $clog2(MAX_PULSES + 1);
   localparam int DIV_W  = 64;
   localparam int DEN_W  = 32;
   localparam int STEP_W = $clog2(DIV_W);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_START  = 2'd1,
      OP_TICK   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_PROC        = 3'd1,
      ST_SHORT       = 3'd2,
      ST_MISMATCH    = 3'd3,
      ST_NOT_STARTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_SEG_COUNT    = 3'd0,
      CSR_VEL_SCALE    = 3'd1,
      CSR_MAX_END_ERR  = 3'd2,
      CSR_STROKE_TICKS = 3'd3,
      CSR_PLAN_MICROS  = 3'd4,
      CSR_END_POS      = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_START,
      S_TICK,
      S_G_INIT,
      S_G_S1,
      S_G_S2,
      S_G_LO1,
      S_G_LO2,
      S_G_HI1,
      S_G_HI2,
      S_G_CHK,
      S_G_RD,
      S_G_MUL,
      S_G_ACC,
      S_G_VN,
      S_G_VD,
      S_G_VW,
      S_G_DONE,
      S_CHK,
      S_REPLY,
      S_SCAN,
      S_DECIDE,
      S_FORM,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== rtl/sip_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module sip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sip_div.sv =====
// radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on sip_pkg
module sip_div
   import sip_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic              div_done,
   output logic [DIV_W-1:0]  div_quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_sh;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

// ===== rtl/stroke_interpolator_step_pulser_top.sv =====
// Four-axis stroke interpolator with step pulse output. One request is worked at a time and
// req_stall stays high until its last result has been placed in the output register. A start
// or tick request that interpolates runs up to seven divisions on the shared divider plus
// multiplies on the shared multiplier, one per axis of each segment read; a tick then emits
// step pulses, up to MAX_PULSES pulses. Results drain through a one-entry output register.
// Depends on sip_pkg, sip_ram and sip_div.
module stroke_interpolator_step_pulser_top
   import sip_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_segment_index,
   input  logic signed [15:0] req_seg_vel_0,
   input  logic signed [15:0] req_seg_vel_1,
   input  logic signed [15:0] req_seg_vel_2,
   input  logic signed [15:0] req_seg_vel_3,
   input  logic [30:0]        req_time_ticks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [1:0]  rsp_pulse_0,
   output logic signed [1:0]  rsp_pulse_1,
   output logic signed [1:0]  rsp_pulse_2,
   output logic signed [1:0]  rsp_pulse_3,
   output logic [2:0]         rsp_status,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   function automatic logic signed [15:0] lane16(input logic [63:0] word, input logic [1:0] sel);
      return word[16*sel +: 16];
   endfunction

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [30:0]      t_ff, t_in;
   logic [4:0]       seg_count_ff, seg_count_in;
   logic [7:0]       vscale_ff, vscale_in;
   logic [14:0]      max_err_ff, max_err_in;
   logic [30:0]      stroke_ff, stroke_in;
   logic [30:0]      plan_ff, plan_in;
   logic [63:0]      end_pos_ff, end_pos_in;
   logic [30:0]      start_ff, start_in;
   logic [30:0]      eff_ff, eff_in;
   logic [31:0]      t_goal_ff, t_goal_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [30:0]      dt_ff, dt_in;
   logic [IDX_W-1:0] s_ff, s_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [30:0]      lo_ff, lo_in;
   logic [30:0]      hi_ff, hi_in;
   logic [30:0]      num_ff, num_in;
   logic [30:0]      den_ff, den_in;
   logic signed [31:0] vel_ff [NUM_AXES];
   logic signed [31:0] vel_in [NUM_AXES];
   logic signed [31:0] base_ff [NUM_AXES];
   logic signed [31:0] base_in [NUM_AXES];
   logic signed [31:0] goal_ff [NUM_AXES];
   logic signed [31:0] goal_in [NUM_AXES];
   logic signed [31:0] pos_ff [NUM_AXES];
   logic signed [31:0] pos_in [NUM_AXES];
   logic [32:0]      abs_ff [NUM_AXES];
   logic [32:0]      abs_in [NUM_AXES];
   logic [NUM_AXES-1:0] neg_ff, neg_in;
   logic [32:0]      dmax_ff, dmax_in;
   logic             pend_ff, pend_in;
   logic [1:0]       pend_p_ff [NUM_AXES];
   logic [1:0]       pend_p_in [NUM_AXES];
   logic [CNT_W-1:0] n_ff, n_in;
   logic [1:0]       ax_ff, ax_in;
   logic             qneg_ff, qneg_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_p_ff [NUM_AXES];
   logic [1:0]       rsp_p_in [NUM_AXES];
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;
   logic signed [63:0] mul_ff, mul_in;
   logic signed [31:0] mul_a, mul_b;

   div_req_type      div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic             ram_we;
   logic [63:0]      ram_rdata;
   logic             accept;
   logic             out_free;

   sip_ram #(
      .WIDTH (64),
      .DEPTH (SEG_MAX)
   ) u_seg_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IDX_W'(req_segment_index)),
      .wdata ({req_seg_vel_3, req_seg_vel_2, req_seg_vel_1, req_seg_vel_0}),
      .raddr (k_ff),
      .rdata (ram_rdata)
   );

   sip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_we    = accept && (req_operation == OP_LOAD) && (32'(req_segment_index) < SEG_MAX);
   assign mul_in    = mul_a * mul_b;

   always_comb begin
      logic             emit;
      logic [1:0]       emit_p [NUM_AXES];
      status_type       emit_status;
      logic             emit_last;
      logic [LEN_W-1:0] len_v;
      logic [31:0]      dt_v;
      logic [30:0]      eff_v;
      logic signed [31:0] nv;
      logic [31:0]      q32;
      logic signed [33:0] chk_d;
      logic [33:0]      chk_a;
      logic signed [32:0] scan_d;
      logic [32:0]      scan_a;
      logic [1:0]       p;

      emit        = 1'b0;
      emit_p      = '{default: 2'b00};
      emit_status = ST_OK;
      emit_last   = 1'b0;
      len_v       = '0;
      dt_v        = '0;
      eff_v       = '0;
      nv          = '0;
      q32         = '0;
      chk_d       = '0;
      chk_a       = '0;
      scan_d      = '0;
      scan_a      = '0;
      p           = 2'b00;

      state_in      = state_ff;
      op_in         = op_ff;
      t_in          = t_ff;
      seg_count_in  = seg_count_ff;
      vscale_in     = vscale_ff;
      max_err_in    = max_err_ff;
      stroke_in     = stroke_ff;
      plan_in       = plan_ff;
      end_pos_in    = end_pos_ff;
      start_in      = start_ff;
      eff_in        = eff_ff;
      t_goal_in     = t_goal_ff;
      len_in        = len_ff;
      dt_in         = dt_ff;
      s_in          = s_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      vel_in        = vel_ff;
      base_in       = base_ff;
      goal_in       = goal_ff;
      pos_in        = pos_ff;
      abs_in        = abs_ff;
      neg_in        = neg_ff;
      dmax_in       = dmax_ff;
      pend_in       = pend_ff;
      pend_p_in     = pend_p_ff;
      n_in          = n_ff;
      ax_in         = ax_ff;
      qneg_in       = qneg_ff;
      res_status_in = res_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SEG_COUNT:    seg_count_in = csr_wdata[4:0];
            CSR_VEL_SCALE:    vscale_in    = csr_wdata[7:0];
            CSR_MAX_END_ERR:  max_err_in   = csr_wdata[14:0];
            CSR_STROKE_TICKS: stroke_in    = csr_wdata[30:0];
            CSR_PLAN_MICROS:  plan_in      = csr_wdata[30:0];
            CSR_END_POS:      end_pos_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               t_in     = req_time_ticks;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_START: state_in = S_START;
               OP_TICK:  state_in = S_TICK;
               default: begin
                  res_status_in = ST_OK;
                  state_in      = S_REPLY;
               end
            endcase
         end
         S_START: begin
            start_in = t_ff;
            if (stroke_ff != '0) begin
               eff_in    = stroke_ff;
               pos_in    = '{default: '0};
               t_goal_in = {1'b0, t_ff} + {1'b0, stroke_ff} - 32'd1;
               state_in  = S_G_INIT;
            end else if (32'(plan_ff) <= 32'(TICK_US)) begin
               eff_in        = '0;
               res_status_in = ST_SHORT;
               state_in      = S_REPLY;
            end else begin
               eff_v     = 31'(({1'b0, plan_ff} + 32'(TICK_US - 1)) / 32'(TICK_US));
               eff_in    = eff_v;
               pos_in    = '{default: '0};
               t_goal_in = {1'b0, t_ff} + {1'b0, eff_v} - 32'd1;
               state_in  = S_G_INIT;
            end
         end
         S_TICK: begin
            if (start_ff == '0) begin
               res_status_in = ST_NOT_STARTED;
               state_in      = S_REPLY;
            end else if ({1'b0, t_ff} > ({1'b0, start_ff} + {1'b0, eff_ff})) begin
               res_status_in = ST_OK;
               state_in      = S_REPLY;
            end else begin
               t_goal_in = {1'b0, t_ff};
               state_in  = S_G_INIT;
            end
         end
         S_G_INIT: begin
            len_v  = (seg_count_ff > SEG_MAX) ? LEN_W'(SEG_MAX) : LEN_W'(seg_count_ff);
            dt_v   = t_goal_ff - {1'b0, start_ff};
            len_in = len_v;
            dt_in  = dt_v[30:0];
            if ((t_goal_ff <= {1'b0, start_ff}) || (eff_ff == '0) || (len_v == '0)) begin
               goal_in  = '{default: '0};
               state_in = S_G_DONE;
            end else if (dt_v >= {1'b0, eff_ff}) begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  goal_in[i] = 32'(lane16(end_pos_ff, 2'(i)));
               end
               state_in = S_G_DONE;
            end else begin
               mul_a    = $signed(dt_v);
               mul_b    = $signed(32'(len_v));
               state_in = S_G_S1;
            end
         end
         S_G_S1: begin
            div_req.start    = 1'b1;
            div_req.dividend = unsigned'(mul_ff) + 64'(len_ff) - 64'd1;
            div_req.divisor  = {1'b0, eff_ff};
            state_in         = S_G_S2;
         end
         S_G_S2: begin
            if (div_done) begin
               s_in     = div_quot[IDX_W-1:0];
               mul_a    = $signed(32'(div_quot[IDX_W-1:0]));
               mul_b    = $signed({1'b0, eff_ff});
               state_in = S_G_LO1;
            end
         end
         S_G_LO1: begin
            div_req.start    = 1'b1;
            div_req.dividend = unsigned'(mul_ff);
            div_req.divisor  = 32'(len_ff);
            state_in         = S_G_LO2;
         end
         S_G_LO2: begin
            if (div_done) begin
               lo_in    = div_quot[30:0];
               mul_a    = $signed(32'(s_ff) + 32'd1);
               mul_b    = $signed({1'b0, eff_ff});
               state_in = S_G_HI1;
            end
         end
         S_G_HI1: begin
            div_req.start    = 1'b1;
            div_req.dividend = unsigned'(mul_ff);
            div_req.divisor  = 32'(len_ff);
            state_in         = S_G_HI2;
         end
         S_G_HI2: begin
            if (div_done) begin
               hi_in    = div_quot[30:0];
               state_in = S_G_CHK;
            end
         end
         S_G_CHK: begin
            if (hi_ff <= lo_ff) begin
               goal_in  = '{default: '0};
               state_in = S_G_DONE;
            end else begin
               num_in   = ((dt_ff > hi_ff) ? hi_ff : dt_ff) - lo_ff;
               den_in   = hi_ff - lo_ff;
               k_in     = '0;
               vel_in   = '{default: '0};
               base_in  = '{default: '0};
               state_in = S_G_RD;
            end
         end
         S_G_RD: begin
            ax_in    = 2'd0;
            state_in = S_G_MUL;
         end
         S_G_MUL: begin
            mul_a    = $signed(32'(lane16(ram_rdata, ax_ff)));
            mul_b    = $signed(32'(vscale_ff));
            state_in = S_G_ACC;
         end
         S_G_ACC: begin
            nv             = vel_ff[ax_ff] + mul_ff[31:0];
            vel_in[ax_ff]  = nv;
            if (k_ff != s_ff) begin
               base_in[ax_ff] = base_ff[ax_ff] + nv;
            end
            if (ax_ff == 2'd3) begin
               if (k_ff == s_ff) begin
                  ax_in    = 2'd0;
                  state_in = S_G_VN;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_G_RD;
               end
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_G_MUL;
            end
         end
         S_G_VN: begin
            mul_a    = vel_ff[ax_ff];
            mul_b    = $signed({1'b0, num_ff});
            state_in = S_G_VD;
         end
         S_G_VD: begin
            qneg_in          = mul_ff[63];
            div_req.start    = 1'b1;
            div_req.dividend = mul_ff[63] ? unsigned'(-mul_ff) : unsigned'(mul_ff);
            div_req.divisor  = {1'b0, den_ff};
            state_in         = S_G_VW;
         end
         S_G_VW: begin
            if (div_done) begin
               q32            = div_quot[31:0];
               goal_in[ax_ff] = base_ff[ax_ff] + (qneg_ff ? -q32 : q32);
               if (ax_ff == 2'd3) begin
                  state_in = S_G_DONE;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_G_VN;
               end
            end
         end
         S_G_DONE: begin
            ax_in    = 2'd0;
            pend_in  = 1'b0;
            n_in     = '0;
            state_in = (op_ff == OP_START) ? S_CHK : S_SCAN;
         end
         S_CHK: begin
            chk_d = 34'(lane16(end_pos_ff, ax_ff)) - 34'(goal_ff[ax_ff]);
            chk_a = chk_d[33] ? unsigned'(-chk_d) : unsigned'(chk_d);
            if (chk_a > 34'(max_err_ff)) begin
               res_status_in = ST_MISMATCH;
               state_in      = S_REPLY;
            end else if (ax_ff == 2'd3) begin
               res_status_in = ST_OK;
               state_in      = S_REPLY;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = res_status_ff;
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            scan_d        = 33'(goal_ff[ax_ff]) - 33'(pos_ff[ax_ff]);
            scan_a        = scan_d[32] ? unsigned'(-scan_d) : unsigned'(scan_d);
            abs_in[ax_ff] = scan_a;
            neg_in[ax_ff] = scan_d[32];
            dmax_in       = ((ax_ff == 2'd0) || (scan_a > dmax_ff)) ? scan_a : dmax_ff;
            if (ax_ff == 2'd3) begin
               state_in = S_DECIDE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_DECIDE: begin
            if ((dmax_ff != '0) && !pend_ff) begin
               state_in = S_FORM;
            end else if (out_free) begin
               emit        = 1'b1;
               emit_status = ST_PROC;
               emit_last   = (dmax_ff == '0);
               if (pend_ff) begin
                  emit_p = pend_p_ff;
               end
               state_in = (dmax_ff == '0) ? S_IDLE : S_FORM;
            end
         end
         S_FORM: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               p            = (abs_ff[i] == dmax_ff) ? (neg_ff[i] ? 2'b11 : 2'b01) : 2'b00;
               pend_p_in[i] = p;
               pos_in[i]    = pos_ff[i] + 32'($signed(p));
            end
            pend_in = 1'b1;
            n_in    = n_ff + CNT_W'(1);
            if (n_ff + CNT_W'(1) == CNT_W'(MAX_PULSES)) begin
               state_in = S_FINAL;
            end else begin
               ax_in    = 2'd0;
               state_in = S_SCAN;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_p      = pend_p_ff;
               emit_status = ST_PROC;
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in  = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_p_in      = emit ? emit_p : rsp_p_ff;
      rsp_status_in = emit ? emit_status : rsp_status_ff;
      rsp_last_in   = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         seg_count_ff <= '0;
         vscale_ff    <= 8'd1;
         max_err_ff   <= 15'd16;
         stroke_ff    <= '0;
         plan_ff      <= '0;
         end_pos_ff   <= '0;
         start_ff     <= '0;
         eff_ff       <= '0;
         pos_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_count_ff <= seg_count_in;
         vscale_ff    <= vscale_in;
         max_err_ff   <= max_err_in;
         stroke_ff    <= stroke_in;
         plan_ff      <= plan_in;
         end_pos_ff   <= end_pos_in;
         start_ff     <= start_in;
         eff_ff       <= eff_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      t_ff          <= t_in;
      t_goal_ff     <= t_goal_in;
      len_ff        <= len_in;
      dt_ff         <= dt_in;
      s_ff          <= s_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      vel_ff        <= vel_in;
      base_ff       <= base_in;
      goal_ff       <= goal_in;
      abs_ff        <= abs_in;
      neg_ff        <= neg_in;
      dmax_ff       <= dmax_in;
      pend_ff       <= pend_in;
      pend_p_ff     <= pend_p_in;
      n_ff          <= n_in;
      ax_ff         <= ax_in;
      qneg_ff       <= qneg_in;
      res_status_ff <= res_status_in;
      rsp_p_ff      <= rsp_p_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      mul_ff        <= mul_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pulse_0 = rsp_p_ff[0];
   assign rsp_pulse_1 = rsp_p_ff[1];
   assign rsp_pulse_2 = rsp_p_ff[2];
   assign rsp_pulse_3 = rsp_p_ff[3];
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTH
   a_mid_is_proc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_PROC))
      else $error("non-final result without processing status");

   a_quiet_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_PROC)) |->
      (rsp_pulse_0 == 2'b00 && rsp_pulse_1 == 2'b00 &&
       rsp_pulse_2 == 2'b00 && rsp_pulse_3 == 2'b00))
      else $error("pulse on a non-processing result");

   a_pulse_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (n_ff < CNT_W'(MAX_PULSES)))
      else $error("pulse count past limit");

   a_div_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_G_S2 || state_ff == S_G_LO2 ||
                    state_ff == S_G_HI2 || state_ff == S_G_VW))
      else $error("divider finished with nobody waiting");
`endif

endmodule
